/* rtl/mtat_pkg.sv */
// Shared types, sizes and codes of the multi-timer action table.
// Used by every module in this folder but mtat_ram; it depends on nothing.
package mtat_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int MAX_STEPS   = 8;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int STEP_W      = $clog2(MAX_STEPS);
  localparam int STEPC_W     = $clog2(MAX_STEPS + 1);
  localparam int RAM_DEPTH   = MAX_ENTRIES * MAX_STEPS;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int TIMER_W     = 34;

  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_ONE_SHOT   = 3'd1;
  localparam logic [2:0] OP_REPEAT     = 3'd2;
  localparam logic [2:0] OP_SEQ_STEP   = 3'd3;
  localparam logic [2:0] OP_CANCEL     = 3'd4;
  localparam logic [2:0] OP_CANCEL_ALL = 3'd5;
  localparam logic [2:0] OP_QUERY      = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [1:0] KIND_REPEAT = 2'd2;
  localparam logic [1:0] KIND_SEQ    = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] time_value;
    logic [15:0] repeat_limit;
    logic        step_last;
    logic [15:0] query_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             fired;
    logic [15:0]      entry_id;
    logic [15:0]      event_index;
    logic             is_active;
    logic [CNT_W-1:0] active_count;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        id;
    logic [1:0]         kind;
    logic               alive;
    logic [TIMER_W-1:0] timer;
    logic [31:0]        interval;
    logic [15:0]        lim;
    logic [15:0]        done;
    logic [STEPC_W-1:0] step_now;
    logic [STEPC_W-1:0] step_total;
    logic [SLOT_W-1:0]  row;
  } slot_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic tick_ex;
    logic tick_fin;
    logic srch;
    logic copy;
    logic send_resp;
    logic send_fire;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_slot;
    logic hit;
    logic go_copy;
    logic copy_end;
    logic emit_end;
    logic no_fire;
  } dp_stat_t;

endpackage

/* rtl/mtat_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the step delays of sequence timers.
module mtat_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mtat_ctrl.sv */
// Sequencing state machine of the timer table: walks, sweeps and result words.
// Depends on mtat_pkg for the command and status structs and op codes.
module mtat_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         in_op,
  input  mtat_pkg::dp_stat_t stat,
  output mtat_pkg::ctl_cmd_t cmd,
  output logic               busy
);
  import mtat_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TRD  = 4'd1;
  localparam logic [3:0] S_TEX  = 4'd2;
  localparam logic [3:0] S_TFIN = 4'd3;
  localparam logic [3:0] S_EMIT = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_COPY = 4'd6;
  localparam logic [3:0] S_SRCH = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_TICK:              state_nxt = stat.empty ? S_TFIN : S_TRD;
            OP_CANCEL, OP_QUERY:  state_nxt = stat.empty ? S_RESP : S_SRCH;
            default:              state_nxt = S_EXEC;
          endcase
        end
      end
      // The step RAM read issued in S_TRD is consumed in S_TEX.
      S_TRD: state_nxt = S_TEX;
      S_TEX: begin
        cmd.tick_ex = 1'b1;
        state_nxt   = stat.last_slot ? S_TFIN : S_TRD;
      end
      S_TFIN: begin
        cmd.tick_fin = 1'b1;
        state_nxt    = stat.no_fire ? S_RESP : S_EMIT;
      end
      S_EMIT: begin
        cmd.send_fire = 1'b1;
        if (stat.emit_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.go_copy ? S_COPY : S_RESP;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.copy_end) begin
          state_nxt = S_RESP;
        end
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        if (stat.hit || stat.last_slot) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        cmd.send_resp = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/mtat_dp.sv */
// Datapath of the timer table: slot registers, step buffer, fire buffer, result word.
// Depends on mtat_pkg and on mtat_ram for the step delay store.
module mtat_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mtat_pkg::in_item_t  in_data,
  input  mtat_pkg::ctl_cmd_t  cmd,
  output mtat_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output mtat_pkg::out_item_t out_data
);
  import mtat_pkg::*;

  in_item_t           in_r;
  out_item_t          resp_r;
  out_item_t          out_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   count_r;
  logic [15:0]        nid_r;
  logic [STEPC_W-1:0] pend_r;
  logic [STEPC_W-1:0] copy_len_r;
  logic [STEP_W-1:0]  c_r;
  logic [SLOT_W-1:0]  row_r;
  logic [SLOT_W-1:0]  i_r;
  logic [CNT_W-1:0]   w_r;
  logic [CNT_W-1:0]   nf_r;
  logic [SLOT_W-1:0]  e_r;
  logic [MAX_ENTRIES-1:0] row_used_r;

  logic [31:0] pbuf_r  [MAX_STEPS];
  logic [15:0] fid_r   [MAX_ENTRIES];
  logic [15:0] fix_r   [MAX_ENTRIES];
  slot_t       slot_r  [MAX_ENTRIES];

  slot_t              cur;
  slot_t              upd;
  slot_t              new_slot;
  logic [15:0]        nid_inc;
  logic [SLOT_W-1:0]  free_row;
  logic               full;
  logic [STEPC_W-1:0] pnew;
  logic [STEPC_W-1:0] sn1;
  logic [15:0]        done1;
  logic [TIMER_W:0]   diff;
  logic [TIMER_W-1:0] t_sub;
  logic [TIMER_W-1:0] t_rearm;
  logic               fire;
  logic [15:0]        fire_idx;
  logic [31:0]        ram_rdata;
  logic [RAM_AW-1:0]  ram_raddr;
  logic               create;
  out_item_t          resp_clear;
  out_item_t          resp_word;
  out_item_t          fire_word;

  assign cur   = slot_r[i_r];
  assign full  = (count_r >= CNT_W'(MAX_ENTRIES));
  assign pnew  = pend_r + 1'b1;
  assign sn1   = cur.step_now + 1'b1;
  assign done1 = cur.done + 16'd1;

  assign nid_inc = (nid_r == 16'hFFFF) ? 16'd1 : nid_r + 16'd1;

  always_comb begin
    free_row = '0;
    for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
      if (!row_used_r[k]) begin
        free_row = SLOT_W'(k);
      end
    end
  end

  // A sequence takes its first delay from the step buffer unless it is a single step.
  always_comb begin
    new_slot            = '0;
    new_slot.id         = nid_r;
    new_slot.kind       = in_r.op[1:0];
    new_slot.alive      = 1'b1;
    new_slot.lim        = in_r.repeat_limit;
    new_slot.row        = free_row;
    new_slot.timer      = {2'b00, in_r.time_value};
    new_slot.interval   = in_r.time_value;
    if (in_r.op == OP_SEQ_STEP) begin
      new_slot.step_total = pnew;
      if (pend_r != '0) begin
        new_slot.timer    = {2'b00, pbuf_r[0]};
        new_slot.interval = pbuf_r[0];
      end
    end
  end

  always_comb begin
    case (in_r.op)
      OP_ONE_SHOT, OP_REPEAT: create = !full;
      OP_SEQ_STEP: create = (pend_r < STEPC_W'(MAX_STEPS)) && in_r.step_last && !full;
      default:     create = 1'b0;
    endcase
  end

  // Tick arithmetic on the slot under the walk pointer; timers saturate at the low end.
  assign diff    = {cur.timer[TIMER_W-1], cur.timer} - {3'b000, in_r.time_value};
  assign t_sub   = (diff[TIMER_W] && !diff[TIMER_W-1]) ? {1'b1, {(TIMER_W-1){1'b0}}}
                                                       : diff[TIMER_W-1:0];
  assign t_rearm = t_sub + {2'b00, cur.interval};
  assign fire    = cur.alive && (t_sub[TIMER_W-1] || (t_sub == '0));

  always_comb begin
    upd       = cur;
    upd.timer = t_sub;
    fire_idx  = '0;
    if (fire) begin
      case (cur.kind)
        KIND_REPEAT: begin
          upd.done = done1;
          fire_idx = done1;
          if ((cur.lim != '0) && (done1 >= cur.lim)) begin
            upd.alive = 1'b0;
          end else begin
            upd.timer = t_rearm;
          end
        end
        KIND_SEQ: begin
          upd.step_now = sn1;
          fire_idx     = 16'(cur.step_now);
          if ((sn1 >= cur.step_total) || (sn1 >= STEPC_W'(MAX_STEPS))) begin
            upd.alive = 1'b0;
          end else begin
            upd.timer = {2'b00, ram_rdata};
          end
        end
        default: upd.alive = 1'b0;
      endcase
    end
  end

  // Result words as they leave the block.
  always_comb begin
    resp_clear              = '0;
    resp_clear.last         = 1'b1;
    resp_word               = resp_r;
    resp_word.active_count  = count_r;
    fire_word               = '0;
    fire_word.fired         = 1'b1;
    fire_word.entry_id      = fid_r[e_r];
    fire_word.event_index   = fix_r[e_r];
    fire_word.active_count  = count_r;
    fire_word.last          = stat.emit_end;
  end

  assign ram_raddr = {cur.row, sn1[STEP_W-1:0]};

  mtat_ram #(
    .DATA_W(32),
    .DEPTH (RAM_DEPTH)
  ) u_step_ram (
    .clk  (clk),
    .we   (cmd.copy),
    .waddr({row_r, c_r}),
    .wdata(pbuf_r[c_r]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      nid_r       <= 16'd1;
      pend_r      <= '0;
      row_used_r  <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      w_r         <= '0;
      nf_r        <= '0;
      e_r         <= '0;
      c_r         <= '0;
    end else begin
      out_valid_r <= cmd.send_resp || cmd.send_fire;
      if (cmd.load) begin
        i_r  <= '0;
        w_r  <= '0;
        nf_r <= '0;
        e_r  <= '0;
        c_r  <= '0;
      end
      if (cmd.exec) begin
        if (create) begin
          count_r              <= count_r + 1'b1;
          nid_r                <= nid_inc;
          row_used_r[free_row] <= 1'b1;
        end
        case (in_r.op)
          OP_CANCEL_ALL: begin
            count_r    <= '0;
            row_used_r <= '0;
          end
          OP_SEQ_STEP: begin
            if (in_r.step_last || (pend_r >= STEPC_W'(MAX_STEPS))) begin
              pend_r <= '0;
            end else begin
              pend_r <= pnew;
            end
          end
          default: ;
        endcase
      end
      if (cmd.tick_ex) begin
        i_r <= i_r + 1'b1;
        if (cur.alive && upd.alive) begin
          w_r <= w_r + 1'b1;
        end else begin
          row_used_r[cur.row] <= 1'b0;
        end
        if (fire) begin
          nf_r <= nf_r + 1'b1;
        end
      end
      if (cmd.tick_fin) begin
        count_r <= w_r;
      end
      if (cmd.srch) begin
        i_r <= i_r + 1'b1;
      end
      if (cmd.copy) begin
        c_r <= c_r + 1'b1;
      end
      if (cmd.send_fire) begin
        e_r <= e_r + 1'b1;
      end
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r   <= in_data;
      resp_r <= resp_clear;
    end
    if (cmd.exec) begin
      case (in_r.op)
        OP_ONE_SHOT, OP_REPEAT: begin
          if (full) begin
            resp_r.status <= ST_FULL;
          end else begin
            resp_r.entry_id <= nid_r;
          end
        end
        OP_SEQ_STEP: begin
          if (pend_r >= STEPC_W'(MAX_STEPS)) begin
            resp_r.status <= ST_TOO_LONG;
          end else begin
            pbuf_r[pend_r[STEP_W-1:0]] <= in_r.time_value;
            if (in_r.step_last) begin
              if (full) begin
                resp_r.status <= ST_FULL;
              end else begin
                resp_r.entry_id <= nid_r;
              end
            end
          end
        end
        default: ;
      endcase
      if (create) begin
        slot_r[count_r[SLOT_W-1:0]] <= new_slot;
        row_r      <= free_row;
        copy_len_r <= pnew;
      end
    end
    if (cmd.tick_ex) begin
      if (cur.alive && upd.alive) begin
        slot_r[w_r[SLOT_W-1:0]] <= upd;
      end
      if (fire) begin
        fid_r[nf_r[SLOT_W-1:0]] <= cur.id;
        fix_r[nf_r[SLOT_W-1:0]] <= fire_idx;
      end
    end
    if (cmd.srch && (cur.id == in_r.query_id)) begin
      if (in_r.op == OP_CANCEL) begin
        slot_r[i_r].alive <= 1'b0;
      end else if (cur.alive) begin
        resp_r.is_active <= 1'b1;
      end
    end
    if (cmd.send_resp) begin
      out_r <= resp_word;
    end
    if (cmd.send_fire) begin
      out_r <= fire_word;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.last_slot = ({1'b0, i_r} == count_r - 1'b1);
  assign stat.hit       = (cur.id == in_r.query_id) && ((in_r.op == OP_CANCEL) || cur.alive);
  assign stat.go_copy   = (in_r.op == OP_SEQ_STEP) && create;
  assign stat.copy_end  = ({1'b0, c_r} == copy_len_r - 1'b1);
  assign stat.emit_end  = ({1'b0, e_r} == nf_r - 1'b1);
  assign stat.no_fire   = (nf_r == '0);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/multi_timer_action_table.sv */
// Top level of the multi-timer action table: controller plus datapath.
// Depends on mtat_pkg, mtat_ctrl, mtat_dp and mtat_ram.
//
// A word is taken when start is high and busy is low; results appear on out_data for one
// cycle each, flagged by out_valid, and cannot be held off. A tick walks the held entries
// in turn, each with a step RAM read (the read is registered), then does the compaction
// count and sends one word per firing, or a single result word when nothing fires.
// Create, step and cancel-all ops run one execute step and send their result word; a
// committed sequence also copies its steps to the step RAM first. Cancel and query scan
// the table one entry per cycle until the first match or the last entry.
module multi_timer_action_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mtat_pkg::in_item_t  in_data,
  output logic                out_valid,
  output mtat_pkg::out_item_t out_data
);
  import mtat_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mtat_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .in_op(in_data.op),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  mtat_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

/* tb/multi_timer_action_table_core_tb.sv */
// Testbench for multi_timer_action_table_core: directed table, then random op streams.
// Results are checked against a built-in model of the timer table; depends on mtat_pkg.
`timescale 1ns / 100ps

module multi_timer_action_table_core_tb;
  import mtat_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [33:0] T_MAX = 34'h1_FFFF_FFFF;
  localparam logic [33:0] T_MIN = 34'h2_0000_0000;
  localparam logic [2:0]  OP_UNUSED = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  multi_timer_action_table_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Model state of the timer table.
  int unsigned       tbl_count;
  logic [15:0]       tbl_next_id;
  logic [15:0]       tbl_id       [MAX_ENTRIES];
  logic [1:0]        tbl_kind     [MAX_ENTRIES];
  logic              tbl_alive    [MAX_ENTRIES];
  logic signed [33:0] tbl_timer   [MAX_ENTRIES];
  logic [31:0]       tbl_interval [MAX_ENTRIES];
  logic [15:0]       tbl_limit    [MAX_ENTRIES];
  logic [15:0]       tbl_done     [MAX_ENTRIES];
  int unsigned       tbl_step_now [MAX_ENTRIES];
  int unsigned       tbl_step_tot [MAX_ENTRIES];
  logic [31:0]       tbl_steps    [MAX_ENTRIES][MAX_STEPS];
  int unsigned       load_count;
  logic [31:0]       load_delay   [MAX_STEPS];

  out_item_t expected_words[$];
  int        error_count;
  int        idle_pct;
  int        watchdog;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  function automatic void queue_word(input out_item_t wd);
    expected_words.insert(expected_words.size(), wd);
  endfunction

  function automatic logic signed [33:0] sat_timer(input logic signed [35:0] v);
    if (v > $signed({2'b00, T_MAX})) return T_MAX;
    if (v < $signed({2'b11, T_MIN})) return T_MIN;
    return v[33:0];
  endfunction

  function automatic out_item_t mk_word(input logic [1:0] st, input logic fi,
                                        input logic [15:0] id, input logic [15:0] ix,
                                        input logic act, input logic lst);
    out_item_t w;
    w.status = st; w.fired = fi; w.entry_id = id; w.event_index = ix;
    w.is_active = act; w.active_count = CNT_W'(tbl_count); w.last = lst;
    return w;
  endfunction

  function automatic logic [15:0] alloc_id();
    logic [15:0] id;
    id = tbl_next_id;
    tbl_next_id = tbl_next_id + 16'd1;
    if (tbl_next_id == 16'd0) tbl_next_id = 16'd1;
    return id;
  endfunction

  function automatic int unsigned add_slot(input logic [1:0] kind, input logic [31:0] t);
    int unsigned s;
    s = tbl_count;
    tbl_id[s] = alloc_id();
    tbl_kind[s] = kind; tbl_alive[s] = 1'b1;
    tbl_timer[s] = {2'b00, t}; tbl_interval[s] = t;
    tbl_limit[s] = '0; tbl_done[s] = '0; tbl_step_now[s] = 0; tbl_step_tot[s] = 0;
    tbl_count++;
    return s;
  endfunction

  task automatic model_reset();
    tbl_count = 0; tbl_next_id = 16'd1; load_count = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) tbl_alive[i] = 1'b0;
  endtask

  // Queues the expected words for one accepted input word.
  task automatic predict_table(input in_item_t it);
    logic [15:0] fid_buf [MAX_ENTRIES];
    logic [15:0] fix_buf [MAX_ENTRIES];
    int unsigned nf;
    logic signed [33:0] t;
    int unsigned s, w;
    logic act;
    act = 1'b0;
    nf = 0;
    case (it.op)
      OP_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_alive[i]) continue;
          t = sat_timer(36'(tbl_timer[i]) - $signed({4'b0, it.time_value}));
          if (t <= 0) begin
            fid_buf[nf] = tbl_id[i];
            if (tbl_kind[i] == KIND_REPEAT) begin
              tbl_done[i] = tbl_done[i] + 16'd1;
              fix_buf[nf] = tbl_done[i];
              if (tbl_limit[i] != 0 && tbl_done[i] >= tbl_limit[i]) tbl_alive[i] = 1'b0;
              else t = sat_timer(36'(t) + $signed({4'b0, tbl_interval[i]}));
            end else if (tbl_kind[i] == KIND_SEQ) begin
              fix_buf[nf] = 16'(tbl_step_now[i]);
              tbl_step_now[i]++;
              if (tbl_step_now[i] >= tbl_step_tot[i] || tbl_step_now[i] >= MAX_STEPS)
                tbl_alive[i] = 1'b0;
              else t = {2'b00, tbl_steps[i][tbl_step_now[i]]};
            end else begin
              fix_buf[nf] = 16'd0;
              tbl_alive[i] = 1'b0;
            end
            nf++;
          end
          tbl_timer[i] = t;
        end
        w = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_alive[i]) begin
            tbl_id[w] = tbl_id[i]; tbl_kind[w] = tbl_kind[i]; tbl_alive[w] = 1'b1;
            tbl_timer[w] = tbl_timer[i]; tbl_interval[w] = tbl_interval[i];
            tbl_limit[w] = tbl_limit[i]; tbl_done[w] = tbl_done[i];
            tbl_step_now[w] = tbl_step_now[i]; tbl_step_tot[w] = tbl_step_tot[i];
            tbl_steps[w] = tbl_steps[i];
            w++;
          end
        end
        for (int i = w; i < MAX_ENTRIES; i++) tbl_alive[i] = 1'b0;
        tbl_count = w;
        if (nf == 0) queue_word(mk_word(ST_OK, 0, 0, 0, 0, 1));
        for (int k = 0; k < nf; k++)
          queue_word(mk_word(ST_OK, 1, fid_buf[k], fix_buf[k], 0, k == nf - 1));
        return;
      end
      OP_ONE_SHOT, OP_REPEAT: begin
        if (tbl_count >= MAX_ENTRIES) begin
          queue_word(mk_word(ST_FULL, 0, 0, 0, 0, 1));
        end else begin
          s = add_slot(it.op[1:0], it.time_value);
          tbl_limit[s] = it.repeat_limit;
          queue_word(mk_word(ST_OK, 0, tbl_id[s], 0, 0, 1));
        end
        return;
      end
      OP_SEQ_STEP: begin
        if (load_count >= MAX_STEPS) begin
          load_count = 0;
          queue_word(mk_word(ST_TOO_LONG, 0, 0, 0, 0, 1));
          return;
        end
        load_delay[load_count] = it.time_value;
        load_count++;
        if (!it.step_last) begin
          queue_word(mk_word(ST_OK, 0, 0, 0, 0, 1));
        end else if (tbl_count >= MAX_ENTRIES) begin
          load_count = 0;
          queue_word(mk_word(ST_FULL, 0, 0, 0, 0, 1));
        end else begin
          s = add_slot(KIND_SEQ, load_delay[0]);
          tbl_step_tot[s] = load_count;
          for (int i = 0; i < load_count; i++) tbl_steps[s][i] = load_delay[i];
          load_count = 0;
          queue_word(mk_word(ST_OK, 0, tbl_id[s], 0, 0, 1));
        end
        return;
      end
      OP_CANCEL: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_id[i] == it.query_id) begin tbl_alive[i] = 1'b0; break; end
      end
      OP_CANCEL_ALL: begin
        tbl_count = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) tbl_alive[i] = 1'b0;
      end
      OP_QUERY: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_id[i] == it.query_id && tbl_alive[i]) begin act = 1'b1; break; end
      end
      default: ;
    endcase
    queue_word(mk_word(ST_OK, 0, 0, 0, act, 1));
  endtask

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          out_item_t e;
          e = expected_words.pop_front();
          if (out_data.status !== e.status)
            report_mismatch($sformatf("status %0d exp %0d", out_data.status, e.status));
          if (out_data.fired !== e.fired)
            report_mismatch($sformatf("fired %0b exp %0b", out_data.fired, e.fired));
          if (out_data.entry_id !== e.entry_id)
            report_mismatch($sformatf("entry_id %0d exp %0d", out_data.entry_id, e.entry_id));
          if (out_data.event_index !== e.event_index)
            report_mismatch($sformatf("event_index %0d exp %0d",
                                      out_data.event_index, e.event_index));
          if (out_data.is_active !== e.is_active)
            report_mismatch($sformatf("is_active %0b exp %0b",
                                      out_data.is_active, e.is_active));
          if (out_data.active_count !== e.active_count)
            report_mismatch($sformatf("active_count %0d exp %0d",
                                      out_data.active_count, e.active_count));
          if (out_data.last !== e.last)
            report_mismatch($sformatf("last %0b exp %0b", out_data.last, e.last));
        end
      end
      if (out_valid || (start && !busy)) watchdog = 0;
      else watchdog++;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Drives one word at the falling edge and holds it until the block takes it.
  // Start stays high afterwards; the next call either replaces the word or idles first.
  task automatic send_word(input in_item_t it);
    int gap;
    gap = 0;
    if (idle_pct > 0) begin
      while ($urandom_range(99) < idle_pct && gap < 12) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    predict_table(it);
    @(negedge clk);
  endtask

  // Drops start so that nothing more is offered to the block.
  task automatic idle_start();
    start <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t make_word(input logic [2:0] op, input logic [31:0] tv,
                                         input logic [15:0] lim, input logic sl,
                                         input logic [15:0] qid);
    in_item_t it;
    it.op = op; it.time_value = tv; it.repeat_limit = lim; it.step_last = sl;
    it.query_id = qid;
    return it;
  endfunction

  // Random payload with short times so that timers fire often.
  function automatic logic [31:0] rand_time();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  function automatic in_item_t rand_word();
    int pick;
    logic [15:0] qid;
    pick = $urandom_range(99);
    qid = ($urandom_range(3) == 0) ? 16'($urandom) : tbl_next_id - 16'($urandom_range(20));
    if (pick < 30)
      return make_word(OP_TICK, rand_time(), 16'($urandom), 1'($urandom_range(1)),
                       16'($urandom));
    if (pick < 45)
      return make_word(OP_ONE_SHOT, rand_time(), 16'($urandom), 1'($urandom_range(1)), qid);
    if (pick < 60)
      return make_word(OP_REPEAT, rand_time(),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
                       1'($urandom_range(1)), qid);
    if (pick < 78)
      return make_word(OP_SEQ_STEP, rand_time(), 16'($urandom),
                       $urandom_range(3) == 0, qid);
    if (pick < 86)
      return make_word(OP_CANCEL, rand_time(), 16'($urandom), 1'($urandom_range(1)), qid);
    if (pick < 88)
      return make_word(OP_CANCEL_ALL, rand_time(), 16'($urandom), 1'($urandom_range(1)),
                       qid);
    if (pick < 97)
      return make_word(OP_QUERY, rand_time(), 16'($urandom), 1'($urandom_range(1)), qid);
    return make_word(OP_UNUSED, $urandom, 16'($urandom), 1'($urandom_range(1)),
                     16'($urandom));
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input in_item_t it);
    dir_row_t r;
    r.it = it; r.typed = 1'b0; r.res = '0;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_typed(input in_item_t it, input out_item_t res);
    dir_row_t r;
    r.it = it; r.typed = 1'b1; r.res = res;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  function automatic out_item_t res_of(input logic [1:0] st, input logic [15:0] id,
                                       input logic act, input int cnt);
    out_item_t r;
    r = '0;
    r.status = st; r.entry_id = id; r.is_active = act;
    r.active_count = CNT_W'(cnt); r.last = 1'b1;
    return r;
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    error_count = 0;
    idle_pct = 0;
    watchdog = 0;
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-table ops, extremes, all ops and an overlong sequence.
    add_typed(make_word(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0), res_of(ST_OK, 0, 0, 0));
    add_typed(make_word(OP_QUERY, 0, 0, 0, 16'hFFFF), res_of(ST_OK, 0, 0, 0));
    add_typed(make_word(OP_ONE_SHOT, 32'd0, 16'hFFFF, 1, 0), res_of(ST_OK, 1, 0, 1));
    add_typed(make_word(OP_REPEAT, 32'hFFFF_FFFF, 16'd2, 0, 0), res_of(ST_OK, 2, 0, 2));
    add_typed(make_word(OP_QUERY, 0, 0, 0, 16'd2), res_of(ST_OK, 0, 1, 2));
    add_row(make_word(OP_REPEAT, 32'h0001_0000, 16'd0, 0, 0));
    add_row(make_word(OP_SEQ_STEP, 32'h0000_8000, 0, 0, 0));
    add_row(make_word(OP_SEQ_STEP, 32'd0, 0, 0, 0));
    add_row(make_word(OP_SEQ_STEP, 32'h0002_0000, 0, 1, 0));
    add_row(make_word(OP_TICK, 32'h0001_0000, 0, 0, 0));
    add_row(make_word(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0));
    add_row(make_word(OP_CANCEL, 0, 0, 0, 16'd3));
    add_row(make_word(OP_CANCEL, 0, 0, 0, 16'd999));
    add_row(make_word(OP_QUERY, 0, 0, 0, 16'd3));
    add_row(make_word(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1, 16'hFFFF));
    for (int i = 0; i < 8; i++) add_row(make_word(OP_SEQ_STEP, 32'h10, 0, 0, 0));
    add_row(make_word(OP_SEQ_STEP, 32'h10, 0, 1, 0));
    add_row(make_word(OP_CANCEL_ALL, 0, 0, 0, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        send_word(dir_rows[i].it);
        expected_words[$] = dir_rows[i].res;
      end else begin
        send_word(dir_rows[i].it);
      end
    end

    // Fill the table to force a full status, then wait for all words to drain.
    for (int i = 0; i < MAX_ENTRIES + 1; i++)
      send_word(make_word(OP_ONE_SHOT, 32'h0001_0000, 16'($urandom), 0, 0));
    send_word(make_word(OP_SEQ_STEP, 32'h5, 0, 1, 0));
    send_word(make_word(OP_TICK, 32'h0001_0000, 0, 0, 0));
    idle_start();
    while (expected_words.size() != 0) @(negedge clk);

    // Random part in idle phases: none, sender 82%, none again, 23%.
    for (int n = 0; n < 400; n++) begin
      case (n / 100)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 0;
        default: idle_pct = 23;
      endcase
      // Once mid-run, let everything drain and clear the table with nothing in flight.
      if (n == 200) begin
        idle_start();
        while (expected_words.size() != 0) @(negedge clk);
        send_word(make_word(OP_CANCEL_ALL, 0, 0, 0, 0));
      end
      send_word(rand_word());
    end

    idle_start();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mtat_pkg.sv
rtl/mtat_ram.sv
rtl/mtat_ctrl.sv
rtl/mtat_dp.sv
rtl/multi_timer_action_table.sv
tb/multi_timer_action_table_core_tb.sv
